>>> design/fcis_pkg.sv
// Shared types and constants for the filtered child insertion sort block.
// No dependencies; used by every module of the block.
`default_nettype none
package fcis_pkg;
  localparam int WORD_W = 64;
  localparam int POS_W = 16;
  localparam int CNT_W = 5;
  localparam int SEEN_W = 17;
  localparam int KEY_W = 5 * WORD_W;

  localparam logic [2:0] REG_PARENT0 = 3'd0;
  localparam logic [2:0] REG_PARENT1 = 3'd1;
  localparam logic [2:0] REG_PARENT2 = 3'd2;
  localparam logic [2:0] REG_PARENT3 = 3'd3;
  localparam logic [2:0] REG_CAPACITY = 3'd4;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic load_out;
    logic clear_run;
  } dp_cmd_t;
endpackage
`default_nettype wire

>>> design/fcis_ctrl.sv
// Controller: accept nodes, then stream the sorted list out one beat at a time.
// Depends on fcis_pkg for the command type.
`default_nettype none
module fcis_ctrl #(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tlast,
  output logic      in_tready,
  input  wire logic out_tready,
  output logic      out_tvalid,
  output logic      out_tlast,
  input  wire logic [$clog2(CAPACITY+1)-1:0] held,
  output fcis_pkg::dp_cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam int HW = $clog2(CAPACITY+1);
  logic [1:0] state_r, state_nxt;
  logic [HW-1:0] idx_r, idx_nxt;
  logic ov_r, ov_nxt, ol_r, ol_nxt;
  logic acc, adv, done;
  logic [HW-1:0] idx_inc;

  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;
  assign adv = !ov_r || out_tready;
  assign idx_inc = idx_r + HW'(1);
  assign done = idx_inc >= held;
  assign out_tvalid = ov_r;
  assign out_tlast = ol_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    ov_nxt = ov_r && !out_tready;
    ol_nxt = ol_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.insert = acc;
        if (acc && in_tlast) begin
          state_nxt = S_EMIT;
          idx_nxt = '0;
        end
      end
      S_EMIT: begin
        if (adv) begin
          cmd.load_out = 1'b1;
          ov_nxt = 1'b1;
          ol_nxt = done;
          idx_nxt = idx_inc;
          if (done) begin
            state_nxt = S_IDLE;
            cmd.clear_run = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      ov_r <= 1'b0;
      ol_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      ov_r <= ov_nxt;
      ol_r <= ol_nxt;
    end
  end
endmodule
`default_nettype wire

>>> design/filtered_child_insertion_sort.sv
// Top level of the filtered child insertion sort block: sorted-list datapath.
// Depends on fcis_pkg and fcis_ctrl.
// Usage: write parent_word0..3 and capacity_in_use on cfg_* while no run is in flight.
// Nodes enter on in_*, one beat per node. A node whose parent matches is inserted
// into a row of compare-and-shift cells in the cycle it is accepted, so a run
// streams in at one node per cycle.
// On the beat with in_tlast the list goes out on out_*: one beat per held entry,
// or one beat with entry_valid low when the list is empty. The first beat is
// loaded into the output register once the controller has entered its emit state
// after the last node is accepted, then one beat per cycle while out_tready is high.
// in_tready is low from the last node's accept until the final beat is loaded,
// so the next run is not accepted while the previous list is still being emitted.
// A stalled receiver holds out_tvalid and out_tdata; emission pauses, nothing is lost.
// Reset returns the registers to their reset values and clears the run counters
// and out_tvalid; list cells are undefined until written and are read only
// below the held count.
`default_nettype none
module filtered_child_insertion_sort #(
  parameter int CAPACITY = 16,
  parameter int MAX_NODES = 65536
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // node_order, node_id_word0..3, up_word0..3
  input  wire logic [575:0] in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // entry_valid, node_position, child_order, child_id_word0..3,
  // emitted_count, truncated, examined_count, pad
  output logic [367:0]      out_tdata,
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  import fcis_pkg::*;
  localparam int HW = $clog2(CAPACITY+1);
  localparam int SW = $clog2(MAX_NODES+1);

  logic [WORD_W-1:0] par_r [4];
  logic [CNT_W-1:0] cap_r;
  entry_t list_r [CAPACITY];
  entry_t shift_in [CAPACITY];
  logic [HW-1:0] held_r;
  logic drop_r;
  logic [SW-1:0] seen_r;
  logic [367:0] od_r;
  dp_cmd_t cmd;

  logic match, full, ins;
  logic [KEY_W-1:0] key;
  logic [POS_W-1:0] pos;
  logic [HW-1:0] capc, held_n;
  logic [CAPACITY-1:0] gt;
  logic drop_n;
  logic [SW-1:0] seen_n;
  entry_t new_e, head;

  fcis_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tlast(in_tlast),
    .in_tready(in_tready),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tlast(out_tlast),
    .held(held_r),
    .cmd(cmd)
  );

  assign key = {in_tdata[63:0], in_tdata[127:64], in_tdata[191:128],
                in_tdata[255:192], in_tdata[319:256]};
  assign match = in_tdata[383:320] == par_r[0] && in_tdata[447:384] == par_r[1] &&
                 in_tdata[511:448] == par_r[2] && in_tdata[575:512] == par_r[3];
  assign pos = (32'(seen_r) > 32'hFFFF) ? {POS_W{1'b1}} : POS_W'(seen_r);
  assign capc = (32'(cap_r) > CAPACITY) ? HW'(CAPACITY) : HW'(cap_r);
  assign full = held_r >= capc;
  assign ins = cmd.insert && match && !full;
  assign held_n = held_r + HW'(ins);
  assign drop_n = drop_r | (cmd.insert && match && full);
  assign seen_n = (32'(seen_r) < MAX_NODES) ? seen_r + SW'(1) : seen_r;
  assign new_e = '{position: pos, key: key};

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) gt[i] = (HW'(i) < held_r) && (list_r[i].key > key);
  end

  always_comb begin
    shift_in[0] = new_e;
    for (int i = 1; i < CAPACITY; i++) shift_in[i] = gt[i-1] ? list_r[i-1] : new_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) par_r[i] <= '0;
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PARENT0: par_r[0] <= cfg_data;
        REG_PARENT1: par_r[1] <= cfg_data;
        REG_PARENT2: par_r[2] <= cfg_data;
        REG_PARENT3: par_r[3] <= cfg_data;
        REG_CAPACITY: cap_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // insert shifts the tail up; emission shifts the list down toward cell 0
  always_ff @(posedge clk) begin
    if (ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (gt[i] || HW'(i) == held_r) list_r[i] <= shift_in[i];
      end
    end else if (cmd.load_out) begin
      for (int i = 0; i + 1 < CAPACITY; i++) list_r[i] <= list_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_run) begin
      held_r <= '0;
      drop_r <= 1'b0;
      seen_r <= '0;
    end else if (cmd.insert) begin
      held_r <= held_n;
      drop_r <= drop_n;
      seen_r <= seen_n;
    end
  end

  assign head = (held_r == '0) ? '0 : list_r[0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      od_r <= {8'd0, SEEN_W'(seen_r), drop_r, CNT_W'(held_r),
               head.key[63:0], head.key[127:64], head.key[191:128], head.key[255:192],
               head.key[319:256], head.position, held_r != '0};
    end
  end

  assign out_tdata = od_r;
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for filtered_child_insertion_sort: streams runs of nodes,
// predicts each sorted child list in a behavioral list model and checks every beat.
// Depends on fcis_pkg for the register indexes.
`timescale 1ns / 1ps
module tb_top;
  import fcis_pkg::*;

  typedef struct packed {
    logic [575:0] data;
    logic         last;
  } node_beat_t;

  typedef struct packed {
    logic [15:0]  position;
    logic [319:0] key;
  } child_t;

  typedef struct packed {
    logic         valid;
    logic [15:0]  position;
    logic [63:0]  order;
    logic [255:0] id;
    logic         last;
    logic [4:0]   count;
    logic         truncated;
    logic [16:0]  examined;
  } child_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [575:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [367:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  node_beat_t node_q[$];
  child_beat_t child_list_q[$];
  logic [63:0] parent_cfg[4];
  logic [4:0] capacity_cfg;
  child_t held_list[16];
  int held_count;
  bit dropped;
  int seen_count;
  bit in_busy;
  bit hold_send;
  bit quiet;
  int errors;
  int runs_done;
  int children_seen;

  filtered_child_insertion_sort DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // insert a matching node into the sorted list and emit the list on the last node
  function automatic void insert_and_emit(logic [575:0] d, logic last);
    logic [319:0] key;
    logic [15:0] pos;
    int cap;
    int j;
    child_beat_t r;
    key = {d[63:0], d[127:64], d[191:128], d[255:192], d[319:256]};
    pos = (seen_count > 65535) ? 16'hFFFF : seen_count[15:0];
    if (seen_count < 65536) seen_count++;
    if (d[383:320] == parent_cfg[0] && d[447:384] == parent_cfg[1] &&
        d[511:448] == parent_cfg[2] && d[575:512] == parent_cfg[3]) begin
      cap = (capacity_cfg > 16) ? 16 : capacity_cfg;
      if (held_count >= cap) begin
        dropped = 1'b1;
      end else begin
        j = held_count;
        while (j > 0 && held_list[j-1].key > key) begin
          held_list[j] = held_list[j-1];
          j--;
        end
        held_list[j] = '{position: pos, key: key};
        held_count++;
      end
    end
    if (!last) return;
    runs_done++;
    if (held_count == 0) begin
      r = '0;
      r.last = 1'b1;
      r.truncated = dropped;
      r.examined = seen_count[16:0];
      child_list_q.push_back(r);
    end
    for (int k = 0; k < held_count; k++) begin
      r.valid = 1'b1;
      r.position = held_list[k].position;
      r.order = held_list[k].key[319:256];
      r.id = held_list[k].key[255:0];
      r.last = (k + 1 == held_count);
      r.count = held_count[4:0];
      r.truncated = dropped;
      r.examined = seen_count[16:0];
      child_list_q.push_back(r);
    end
    held_count = 0;
    dropped = 1'b0;
    seen_count = 0;
  endfunction

  // accept, predict and check at the rising edge
  always @(posedge clk) begin
    child_beat_t got;
    child_beat_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        insert_and_emit(in_tdata, in_tlast);
        void'(node_q.pop_front());
        in_busy = 1'b0;
      end
      if (out_tvalid && out_tready) begin
        got.valid = out_tdata[0];
        got.position = out_tdata[16:1];
        got.order = out_tdata[80:17];
        got.id = {out_tdata[144:81], out_tdata[208:145], out_tdata[272:209],
                  out_tdata[336:273]};
        got.last = out_tlast;
        got.count = out_tdata[341:337];
        got.truncated = out_tdata[342];
        got.examined = out_tdata[359:343];
        children_seen++;
        if (child_list_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: %h", got);
        end else begin
          want = child_list_q.pop_front();
          if (got.valid !== want.valid || got.position !== want.position ||
              got.order !== want.order || got.id !== want.id || got.last !== want.last ||
              got.count !== want.count || got.truncated !== want.truncated ||
              got.examined !== want.examined) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp v=%0d pos=%0d ord=%h id=%h last=%0d cnt=%0d tr=%0d ex=%0d",
                       want.valid, want.position, want.order, want.id, want.last,
                       want.count, want.truncated, want.examined);
              $display("          got v=%0d pos=%0d ord=%h id=%h last=%0d cnt=%0d tr=%0d ex=%0d",
                       got.valid, got.position, got.order, got.id, got.last,
                       got.count, got.truncated, got.examined);
            end
          end
        end
      end
    end
  end

  // drive both handshakes at the falling edge
  always @(negedge clk) begin
    if (!in_busy) begin
      if (rst_n && !hold_send && node_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
        in_tvalid <= 1'b1;
        in_tdata <= node_q[0].data;
        in_tlast <= node_q[0].last;
        in_busy = 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && (quiet || $urandom_range(0, 99) >= 15);
  end

  task automatic add_node(logic [63:0] order, logic [255:0] id, logic [255:0] up, logic last);
    node_beat_t b;
    b.data = {up[63:0], up[127:64], up[191:128], up[255:192],
              id[63:0], id[127:64], id[191:128], id[255:192], order};
    b.last = last;
    node_q.push_back(b);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx < REG_CAPACITY) parent_cfg[idx] = value;
    else if (idx == REG_CAPACITY) capacity_cfg = value[4:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (node_q.size() == 0 && !in_busy && child_list_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_parent(logic [255:0] p);
    set_reg(REG_PARENT0, p[255:192]);
    set_reg(REG_PARENT1, p[191:128]);
    set_reg(REG_PARENT2, p[127:64]);
    set_reg(REG_PARENT3, p[63:0]);
  endtask

  // random run: narrow values force ties in order and id
  task automatic random_run(int len, int match_pct, bit narrow);
    logic [255:0] par;
    logic [255:0] up;
    logic [255:0] id;
    logic [63:0] order;
    par = {parent_cfg[0], parent_cfg[1], parent_cfg[2], parent_cfg[3]};
    for (int i = 0; i < len; i++) begin
      order = narrow ? 64'($urandom_range(0, 3)) : rnd64();
      id = narrow ? {62'(0), 2'($urandom_range(0, 3)), 62'(0), 2'($urandom_range(0, 3)),
                     62'(0), 2'($urandom_range(0, 3)), 62'(0), 2'($urandom_range(0, 3))}
                  : {rnd64(), rnd64(), rnd64(), rnd64()};
      if ($urandom_range(0, 99) < match_pct) up = par;
      else if ($urandom_range(0, 1)) up = par ^ (256'd1 << $urandom_range(0, 255));
      else up = {rnd64(), rnd64(), rnd64(), rnd64()};
      add_node(order, id, up, i == len - 1);
    end
  endtask

  initial begin
    logic [255:0] ones;
    int target;
    ones = '1;
    target = 0;
    parent_cfg = '{default: '0};
    capacity_cfg = 5'd16;
    held_count = 0;
    dropped = 1'b0;
    seen_count = 0;
    in_busy = 1'b0;
    hold_send = 1'b0;
    quiet = 1'b0;
    errors = 0;
    runs_done = 0;
    children_seen = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, extremes, ties, stable order of equal keys
    add_node('1, '1, '0, 1'b0);
    add_node('0, '0, '0, 1'b0);
    add_node(64'd5, 256'd2, '0, 1'b0);
    add_node(64'd5, 256'd1, '0, 1'b0);
    add_node(64'd5, {64'd1, 192'd0}, '0, 1'b0);
    add_node(64'd5, 256'd1, '0, 1'b0);
    add_node(64'd7, '1, 256'd1, 1'b0);
    add_node(64'd5, 256'd1, '0, 1'b1);
    add_node(64'd3, '0, ones, 1'b1);
    drain();
    set_reg(3'd5, rnd64());
    set_reg(3'd7, '1);
    set_parent(ones);
    set_reg(REG_CAPACITY, '0);
    add_node(64'd1, '0, ones, 1'b0);
    add_node(64'd2, '1, ones, 1'b1);
    drain();
    set_reg(REG_CAPACITY, 64'hFFFF_FFFF_FFFF_FFFF);
    quiet = 1'b1;
    random_run(20, 100, 1'b1);
    drain();
    quiet = 1'b0;

    // random phases with assorted settings
    for (int ph = 0; ph < 8; ph++) begin
      set_parent({rnd64(), rnd64(), rnd64(), rnd64()});
      set_reg(REG_CAPACITY, (ph == 0) ? 64'd1 : 64'($urandom_range(0, 31)));
      for (int r = 0; r < 3; r++) begin
        random_run($urandom_range(1, 14), $urandom_range(40, 95), $urandom_range(0, 1));
        if (r == 1) begin
          // hold the second run back until the first run's list is fully out
          target = runs_done + 1;
          wait (runs_done >= target);
          hold_send = 1'b1;
          wait (child_list_q.size() == 0);
          repeat (3) @(posedge clk);
          hold_send = 1'b0;
        end
      end
      drain();
    end
    repeat (20) @(posedge clk);

    $display("covered %0d runs and %0d result beats with capacity 0, 1, 16, 31 and random,",
             runs_done, children_seen);
    $display("ties on order and id, empty lists, truncation and output stalls");
    if (errors == 0 && child_list_q.size() == 0) begin
      $display("[filtered_child_insertion_sort] OK");
    end else begin
      $display("mismatches: %0d, beats outstanding: %0d", errors, child_list_q.size());
      $display("[filtered_child_insertion_sort] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d nodes and %0d beats outstanding", node_q.size(),
             child_list_q.size());
    $display("[filtered_child_insertion_sort] ERROR");
    $finish;
  end
endmodule
